// ===== design/yrd_pkg.sv =====
`default_nettype none
package yrd_pkg;

	// frame size limit and derived widths
	localparam int MAX_DIMENSION = 1024;
	localparam int MAX_EVEN      = (MAX_DIMENSION / 2) * 2;
	localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
	localparam int CFG_W         = 11;
	localparam int EXT_W         = (CFG_W > DIM_W) ? CFG_W : DIM_W;
	localparam int ACC_W         = 2 * DIM_W + 1;
	localparam int POS_W         = 10;
	localparam int QUEUE_DEPTH   = 4;

	// register reset values
	localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = CFG_W'(160);
	localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = CFG_W'(120);
	localparam logic [CFG_W-1:0] DST_WIDTH_RST  = CFG_W'(32);
	localparam logic [CFG_W-1:0] DST_HEIGHT_RST = CFG_W'(24);

	// register indexes
	typedef enum logic [1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DST_WIDTH,
		REG_DST_HEIGHT
	} cfg_index_t;

	// one input item: a yuyv macropixel
	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} yuyv_pair_t;

	// one result item: a kept rgb pixel
	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [POS_W-1:0] out_column;
		logic [POS_W-1:0] out_row;
		logic             last_of_item;
		logic             end_of_frame;
	} rgb_pixel_t;

	// decimation verdict for one pixel of a pair
	typedef struct packed {
		logic             keep;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             eof;
	} pixel_tag_t;

	// classified item passed from front to back
	typedef struct packed {
		yuyv_pair_t pair;
		pixel_tag_t tag0;
		pixel_tag_t tag1;
	} queue_entry_t;

endpackage
`default_nettype wire

// ===== design/yrd_front.sv =====
`default_nettype none
module yrd_front import yrd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire yuyv_pair_t   pair,
	input  wire logic         cfg_we,
	input  wire cfg_index_t   cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic         q_full,
	output logic              q_push,
	output queue_entry_t      q_entry
);

	typedef struct packed {
		logic [DIM_W-1:0]        sc;
		logic [DIM_W-1:0]        sr;
		logic [DIM_W-1:0]        ndc;
		logic [DIM_W-1:0]        ndr;
		logic signed [ACC_W-1:0] cacc;
		logic signed [ACC_W-1:0] racc;
		logic                    row_kept;
	} dec_state_t;

	localparam dec_state_t DEC_RESET = '{
		sc: '0, sr: '0, ndc: '0, ndr: '0, cacc: '0, racc: '0, row_kept: 1'b1
	};

	logic [CFG_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [EXT_W-1:0] sw_x, sh_x, dw_x, dh_x;
	logic [DIM_W-1:0] sw, sh, dw, dh;
	dec_state_t       st_q, st_mid, st_next;
	pixel_tag_t       tag0, tag1;
	logic             accept;

	// one pixel of the decimation walk
	function automatic dec_state_t step(
		input  dec_state_t       s,
		input  logic [DIM_W-1:0] w_src,
		input  logic [DIM_W-1:0] h_src,
		input  logic [DIM_W-1:0] w_dst,
		input  logic [DIM_W-1:0] h_dst,
		output pixel_tag_t       tag
	);
		dec_state_t              n;
		logic [DIM_W:0]          col_inc;
		logic [DIM_W:0]          row_inc;
		logic signed [ACC_W-1:0] sw_a, sh_a, dw_a, dh_a;
		n = s;
		sw_a = ACC_W'($signed({1'b0, w_src}));
		sh_a = ACC_W'($signed({1'b0, h_src}));
		dw_a = ACC_W'($signed({1'b0, w_dst}));
		dh_a = ACC_W'($signed({1'b0, h_dst}));
		tag.keep = 1'b0;
		tag.column = POS_W'(s.ndc);
		tag.row = POS_W'(s.ndr);
		tag.eof = (s.ndc == w_dst - 1'b1) && (s.ndr == h_dst - 1'b1);
		if (s.row_kept && (s.ndc < w_dst) && !s.cacc[ACC_W-1] && (s.cacc < dw_a)) begin
			tag.keep = 1'b1;
			n.ndc = s.ndc + 1'b1;
			n.cacc = s.cacc + sw_a;
		end
		n.cacc = n.cacc - dw_a;
		col_inc = {1'b0, s.sc} + 1'b1;
		row_inc = {1'b0, s.sr} + 1'b1;
		if (col_inc >= {1'b0, w_src}) begin
			// row end
			n.sc = '0;
			n.ndc = '0;
			n.cacc = '0;
			if (row_inc >= {1'b0, h_src}) begin
				n = DEC_RESET;
			end else begin
				if (s.row_kept) begin
					n.ndr = s.ndr + 1'b1;
					n.racc = s.racc + sh_a;
				end
				n.sr = row_inc[DIM_W-1:0];
				n.racc = n.racc - dh_a;
				n.row_kept = (n.ndr < h_dst) && !n.racc[ACC_W-1] && (n.racc < dh_a);
			end
		end else begin
			n.sc = col_inc[DIM_W-1:0];
		end
		return n;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			dst_width_q  <= DST_WIDTH_RST;
			dst_height_q <= DST_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective frame sizes after clamping
	always_comb begin
		sw_x = EXT_W'(src_width_q) & ~EXT_W'(1);
		if (sw_x < EXT_W'(2)) sw_x = EXT_W'(2);
		else if (sw_x > EXT_W'(MAX_EVEN)) sw_x = EXT_W'(MAX_EVEN);
		sh_x = EXT_W'(src_height_q);
		if (sh_x < EXT_W'(1)) sh_x = EXT_W'(1);
		else if (sh_x > EXT_W'(MAX_DIMENSION)) sh_x = EXT_W'(MAX_DIMENSION);
		dw_x = EXT_W'(dst_width_q);
		if (dw_x < EXT_W'(1)) dw_x = EXT_W'(1);
		else if (dw_x > sw_x) dw_x = sw_x;
		dh_x = EXT_W'(dst_height_q);
		if (dh_x < EXT_W'(1)) dh_x = EXT_W'(1);
		else if (dh_x > sh_x) dh_x = sh_x;
		sw = DIM_W'(sw_x);
		sh = DIM_W'(sh_x);
		dw = DIM_W'(dw_x);
		dh = DIM_W'(dh_x);
	end

	// classify both pixels of the pair
	always_comb begin
		st_mid  = step(st_q, sw, sh, dw, dh, tag0);
		st_next = step(st_mid, sw, sh, dw, dh, tag1);
	end

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign q_push  = accept && (tag0.keep || tag1.keep);
	assign q_entry = '{pair: pair, tag0: tag0, tag1: tag1};

	// decimation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DEC_RESET;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

endmodule
`default_nettype wire

// ===== design/yrd_queue.sv =====
`default_nettype none
module yrd_queue import yrd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire queue_entry_t wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output queue_entry_t      rd_data,
	output logic              empty
);

	// depth is a power of two so the pointers wrap by themselves
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	queue_entry_t     slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) slots_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/yrd_back.sv =====
`default_nettype none
module yrd_back import yrd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	input  wire queue_entry_t q_entry,
	output logic              q_pop,
	output logic              empty,
	input  wire logic         pop,
	output rgb_pixel_t        pixel
);

	queue_entry_t     cur_s1;
	logic [1:0]       pend_q, pend_after;
	rgb_pixel_t       out_q, conv;
	logic             out_valid_q, free, emit, sel1;
	logic [7:0]       y_sel;
	pixel_tag_t       tag_sel;
	logic signed [8:0]  c, d, e;
	logic signed [19:0] r_sum, g_sum, b_sum;

	// floor by 256 and clamp to a byte
	function automatic logic [7:0] clamp8(input logic signed [19:0] sum);
		logic signed [11:0] q;
		q = 12'(sum >>> 8);
		if (q < 12'sd0) return 8'd0;
		else if (q > 12'sd255) return 8'd255;
		else return q[7:0];
	endfunction

	assign free  = !out_valid_q || pop;
	assign emit  = free && (pend_q != 2'b00);
	assign sel1  = !pend_q[0];

	// pending pixels once this cycle's one is sent
	always_comb begin
		pend_after = pend_q;
		if (emit) begin
			if (pend_q[0]) pend_after[0] = 1'b0;
			else pend_after[1] = 1'b0;
		end
	end

	assign q_pop = !q_empty && (pend_after == 2'b00);

	// bt.601 conversion of the selected pixel
	always_comb begin
		y_sel   = sel1 ? cur_s1.pair.luma_second : cur_s1.pair.luma_first;
		tag_sel = sel1 ? cur_s1.tag1 : cur_s1.tag0;
		c = $signed({1'b0, y_sel}) - 9'sd16;
		d = $signed({1'b0, cur_s1.pair.chroma_blue}) - 9'sd128;
		e = $signed({1'b0, cur_s1.pair.chroma_red}) - 9'sd128;
		r_sum = 20'sd298 * 20'(c) + 20'sd409 * 20'(e) + 20'sd128;
		g_sum = 20'sd298 * 20'(c) - 20'sd100 * 20'(d) - 20'sd208 * 20'(e) + 20'sd128;
		b_sum = 20'sd298 * 20'(c) + 20'sd516 * 20'(d) + 20'sd128;
		conv.red          = clamp8(r_sum);
		conv.green        = clamp8(g_sum);
		conv.blue         = clamp8(b_sum);
		conv.out_column   = tag_sel.column;
		conv.out_row      = tag_sel.row;
		conv.last_of_item = sel1 || !pend_q[1];
		conv.end_of_frame = tag_sel.eof;
	end

	// current item payload and output pixel register
	always_ff @(posedge clk) begin
		if (q_pop) cur_s1 <= q_entry;
		if (emit) out_q <= conv;
	end

	// pending flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 2'b00;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= q_pop ? {q_entry.tag1.keep, q_entry.tag0.keep} : pend_after;
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	assign empty = !out_valid_q;
	assign pixel = out_q;

endmodule
`default_nettype wire

// ===== design/yuyv_to_rgb_downscaler_core.sv =====
`default_nettype none
// yuyv to rgb downscaler
// input channel: a yuyv macropixel (pair) is taken at an edge with push high
// and full low. items arrive in raster order of the source frame.
// result channel: while empty is low the oldest kept rgb pixel is on pixel;
// it is taken at an edge with pop high. each item gives 0, 1 or 2 pixels,
// first pixel first, last_of_item on the final one of the item.
// configuration: cfg_we writes cfg_data into register cfg_index at once
// (source width, source height, destination width, destination height).
// path: an item's first pixel passes a queue slot, the back-end item register
// and the output register. throughput: one item per cycle while pop is high,
// for items keeping at most one pixel; one keeping two is held back by the
// single-pixel output register. a 4-entry queue separates the classifying
// front end from the colour back end; items that keep no pixel never enter it.
// when pop stays low the output holds, the queue fills and full rises.
// reset clears the frame position, queue and output and reloads the
// registers with 160x120 to 32x24; no clearing pass is needed.
module yuyv_to_rgb_downscaler_core import yrd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire yuyv_pair_t       pair,
	output logic                  empty,
	input  wire logic             pop,
	output rgb_pixel_t            pixel,
	input  wire logic             cfg_we,
	input  wire cfg_index_t       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic         q_push, q_full, q_pop, q_empty;
	queue_entry_t q_wr_entry, q_rd_entry;

	yrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pair      (pair),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_wr_entry)
	);

	yrd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_entry),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_entry),
		.empty   (q_empty)
	);

	yrd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_entry (q_rd_entry),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.pixel   (pixel)
	);

endmodule
`default_nettype wire

// ===== design/yrd_checker.sv =====
`default_nettype none
module yrd_checker import yrd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire rgb_pixel_t pixel
);

	// the frame's last pixel closes its item, or the item goes on at the next frame's origin
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && pixel.end_of_frame && !pixel.last_of_item |=>
		(pixel.out_column == 10'd0) && (pixel.out_row == 10'd0))
		else $error("end_of_frame followed by a pixel away from the origin");

	// second pixel of an item follows straight away
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !pixel.last_of_item |=> !empty)
		else $error("second pixel of item not ready");

	// second pixel sits one column to the right on the same row, or opens a new row
	a_pair_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !pixel.last_of_item |=>
		((pixel.out_column == $past(pixel.out_column) + 10'd1) &&
		(pixel.out_row == $past(pixel.out_row))) ||
		(pixel.out_column == 10'd0))
		else $error("pixels of one item not adjacent");

	// a waiting item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel))
		else $error("waiting item changed");

endmodule

bind yuyv_to_rgb_downscaler_core yrd_checker u_chk (.*);
`default_nettype wire

// ===== test/tb_yuyv_to_rgb_downscaler_core.sv =====
`timescale 1ns / 100ps
module tb_yuyv_to_rgb_downscaler_core;
	import yrd_pkg::*;

	// cycles with no handshake on either side before the run is abandoned;
	// well above the longest hold-off and the longest random gap
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	yuyv_pair_t pair      = '0;
	logic       pop       = 1'b0;
	logic       cfg_we    = 1'b0;
	cfg_index_t cfg_index = REG_SRC_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic       full;
	logic       empty;
	rgb_pixel_t pixel;

	// register mirror and frame position of the predictor
	logic [CFG_W-1:0] cfg_src_w, cfg_src_h, cfg_dst_w, cfg_dst_h;
	int  pos_col, pos_row, dst_col, dst_row, col_err, row_err;
	bit  row_live;

	rgb_pixel_t expected_pixels [$];
	int error_count    = 0;
	int pairs_sent     = 0;
	int pixels_checked = 0;
	int frame_ends     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_pending   = 1'b0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	yuyv_to_rgb_downscaler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pair      (pair),
		.empty     (empty),
		.pop       (pop),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// frame position back to the top-left corner
	function automatic void clear_position();
		pos_col  = 0;
		pos_row  = 0;
		dst_col  = 0;
		dst_row  = 0;
		col_err  = 0;
		row_err  = 0;
		row_live = 1'b1;
	endfunction

	// effective frame sizes after clamping
	function automatic int src_cols();
		int v;
		v = int'(cfg_src_w) & ~1;
		if (v < 2) v = 2;
		if (v > MAX_EVEN) v = MAX_EVEN;
		return v;
	endfunction

	function automatic int src_rows();
		int v;
		v = int'(cfg_src_h);
		if (v < 1) v = 1;
		if (v > MAX_DIMENSION) v = MAX_DIMENSION;
		return v;
	endfunction

	function automatic int clamp_dest(logic [CFG_W-1:0] raw, int limit);
		int v;
		v = int'(raw);
		if (v < 1) v = 1;
		if (v > limit) v = limit;
		return v;
	endfunction

	// floor shift by 8 and clamp to a byte
	function automatic logic [7:0] to_byte(int sum);
		int q;
		q = sum >>> 8;
		if (q < 0) return 8'd0;
		if (q > 255) return 8'd255;
		return q[7:0];
	endfunction

	// one source pixel through the decimation counters; true when kept
	function automatic bit advance_pixel(output logic [POS_W-1:0] col,
		output logic [POS_W-1:0] row, output logic eof);
		int sw, sh, dw, dh;
		bit kept;
		sw   = src_cols();
		sh   = src_rows();
		dw   = clamp_dest(cfg_dst_w, sw);
		dh   = clamp_dest(cfg_dst_h, sh);
		kept = 1'b0;
		col  = '0;
		row  = '0;
		eof  = 1'b0;
		if (row_live && dst_col < dw && col_err >= 0 && col_err < dw) begin
			kept = 1'b1;
			col  = POS_W'(dst_col);
			row  = POS_W'(dst_row);
			eof  = (dst_col == dw - 1) && (dst_row == dh - 1);
			dst_col++;
			col_err += sw;
		end
		pos_col++;
		col_err -= dw;
		// row end, and frame end on the last row
		if (pos_col >= sw) begin
			pos_col = 0;
			dst_col = 0;
			col_err = 0;
			if (pos_row + 1 >= sh) begin
				clear_position();
			end else begin
				if (row_live) begin
					dst_row++;
					row_err += sh;
				end
				pos_row++;
				row_err -= dh;
				row_live = dst_row < dh && row_err >= 0 && row_err < dh;
			end
		end
		return kept;
	endfunction

	// expected pixels of one accepted pair
	function automatic void predict_pair(yuyv_pair_t p);
		rgb_pixel_t px [2];
		logic [POS_W-1:0] col, row;
		logic eof;
		int d, e, c, n;
		d = int'(p.chroma_blue) - 128;
		e = int'(p.chroma_red) - 128;
		n = 0;
		for (int k = 0; k < 2; k++) begin
			if (advance_pixel(col, row, eof)) begin
				c = int'(k == 0 ? p.luma_first : p.luma_second) - 16;
				px[n].red          = to_byte(298 * c + 409 * e + 128);
				px[n].green        = to_byte(298 * c - 100 * d - 208 * e + 128);
				px[n].blue         = to_byte(298 * c + 516 * d + 128);
				px[n].out_column   = col;
				px[n].out_row      = row;
				px[n].last_of_item = 1'b0;
				px[n].end_of_frame = eof;
				n++;
			end
		end
		if (n > 0) px[n - 1].last_of_item = 1'b1;
		for (int k = 0; k < n; k++) expected_pixels.push_back(px[k]);
	endfunction

	// a frame boundary has just passed; after a mid-frame width change a pair
	// can straddle it, leaving the position at column one
	function automatic bit at_frame_start();
		return pos_col <= 1 && pos_row == 0;
	endfunction

	function automatic yuyv_pair_t random_pair();
		return yuyv_pair_t'($urandom);
	endfunction

	function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// receiver: checks each pixel taken, then picks pop for the next cycle
	always @(posedge clk) begin
		rgb_pixel_t want;
		if (arst_n && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel: nothing expected, got col %0d row %0d",
					pixel.out_column, pixel.out_row);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("red", want.red, pixel.red);
				check_field("green", want.green, pixel.green);
				check_field("blue", want.blue, pixel.blue);
				check_field("out_column", want.out_column, pixel.out_column);
				check_field("out_row", want.out_row, pixel.out_row);
				check_field("last_of_item", want.last_of_item, pixel.last_of_item);
				check_field("end_of_frame", want.end_of_frame, pixel.end_of_frame);
			end
			pixels_checked++;
			if (pixel.end_of_frame) frame_ends++;
		end
		if (hold_pending) begin
			hold_left    = HOLD_CYCLES;
			hold_pending = 1'b0;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("tb_yuyv_to_rgb_downscaler_core: errors");
					$finish;
				end
			end
		end
	end

	// offer one item after a random gap and wait until it is taken
	task automatic send_pair(yuyv_pair_t p);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		pair <= p;
		do @(posedge clk); while (full);
		predict_pair(p);
		pairs_sent++;
	endtask

	// sender quiet until every expected pixel is out, then a short settle
	task automatic wait_for_pixels();
		push <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all four registers on consecutive cycles
	task automatic program_frame(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
		logic [CFG_W-1:0] dw, logic [CFG_W-1:0] dh);
		cfg_index_t regs [4];
		logic [CFG_W-1:0] vals [4];
		regs = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT};
		vals = '{sw, sh, dw, dh};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		cfg_src_w = sw;
		cfg_src_h = sh;
		cfg_dst_w = dw;
		cfg_dst_h = dh;
	endtask

	// random items until the predictor is back at the frame origin
	task automatic finish_frame();
		do send_pair(random_pair()); while (!at_frame_start());
	endtask

	// small random frame sizes, with out-of-range values now and then
	task automatic program_random_frame();
		logic [CFG_W-1:0] sw, sh, dw, dh;
		case ($urandom_range(15))
			0: sw = 11'd0;
			1: sw = 11'd1;
			2: sw = CFG_W'($urandom_range(40, 64));
			default: sw = CFG_W'($urandom_range(2, 20));
		endcase
		sh = CFG_W'($urandom_range(0, 10));
		case ($urandom_range(7))
			0: dw = 11'd0;
			1: dw = 11'd2047;
			default: dw = CFG_W'($urandom_range(1, int'(sw) + 2));
		endcase
		case ($urandom_range(7))
			0: dh = 11'd0;
			1: dh = 11'd2047;
			default: dh = CFG_W'($urandom_range(1, int'(sh) + 2));
		endcase
		program_frame(sw, sh, dw, dh);
	endtask

	// every pixel kept; extreme and mid-scale luma and chroma over two frames
	task automatic test_colour_extremes();
		yuyv_pair_t p;
		program_frame(11'd4, 11'd3, 11'd4, 11'd3);
		for (int k = 0; k < 12; k++) begin
			case (k)
				8:  p = '{8'd16, 8'd128, 8'd235, 8'd128};
				9:  p = '{8'd235, 8'd16, 8'd16, 8'd240};
				10: p = '{8'd128, 8'd0, 8'd127, 8'd255};
				11: p = '{8'd255, 8'd255, 8'd0, 8'd0};
				default: p = '{k[0] ? 8'd255 : 8'd0, k[1] ? 8'd255 : 8'd0,
					k[0] ? 8'd0 : 8'd255, k[2] ? 8'd255 : 8'd0};
			endcase
			send_pair(p);
		end
		wait_for_pixels();
	endtask

	// register values below and above their ranges
	task automatic test_register_clamping();
		program_frame(11'd1, 11'd0, 11'd0, 11'd2047);
		repeat (3) send_pair(random_pair());
		wait_for_pixels();
		program_frame(11'd7, 11'd3, 11'd2047, 11'd0);
		finish_frame();
		wait_for_pixels();
	endtask

	// widest frame: one line of 1024 pixels, all kept
	task automatic test_wide_frame();
		program_frame(11'd2047, 11'd1, 11'd2047, 11'd5);
		finish_frame();
		wait_for_pixels();
	endtask

	// tallest frame: 1024 lines of two pixels, all kept
	task automatic test_tall_frame();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		program_frame(11'd2, 11'd1024, 11'd2, 11'd1024);
		finish_frame();
		wait_for_pixels();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// receiver holds off while items keep coming, so the block fills up
	task automatic test_backpressure();
		program_frame(11'd8, 11'd4, 11'd8, 11'd4);
		hold_pending = 1'b1;
		repeat (16) send_pair(random_pair());
		wait_for_pixels();
	endtask

	// frame sizes changed part way through a frame
	task automatic test_mid_frame_write();
		program_frame(11'd12, 11'd6, 11'd5, 11'd3);
		repeat (10) send_pair(random_pair());
		wait_for_pixels();
		program_frame(11'd8, 11'd5, 11'd7, 11'd4);
		finish_frame();
		wait_for_pixels();
	endtask

	// random frames under each idling pattern, some cut short by a rewrite
	task automatic test_random_frames();
		int send_pcts [4];
		int recv_pcts [4];
		int target;
		send_pcts = '{0, 75, 0, 20};
		recv_pcts = '{0, 0, 75, 20};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			target         = pairs_sent + 30;
			while (pairs_sent < target) begin
				program_random_frame();
				if ($urandom_range(3) == 0) begin
					repeat ($urandom_range(1, 8)) send_pair(random_pair());
					wait_for_pixels();
					program_random_frame();
				end
				finish_frame();
				wait_for_pixels();
			end
		end
	endtask

	// sequence
	initial begin
		cfg_src_w = SRC_WIDTH_RST;
		cfg_src_h = SRC_HEIGHT_RST;
		cfg_dst_w = DST_WIDTH_RST;
		cfg_dst_h = DST_HEIGHT_RST;
		clear_position();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_colour_extremes();
		test_register_clamping();
		test_backpressure();
		test_mid_frame_write();
		test_wide_frame();
		test_tall_frame();
		test_random_frames();

		wait_for_pixels();
		repeat (20) @(posedge clk);
		$display("run: %0d pairs in, %0d pixels checked, %0d frame ends seen",
			pairs_sent, pixels_checked, frame_ends);
		$display("run: colour extremes, clamped registers, 1024-wide and 1024-tall %s",
			"frames, hold-off, mid-frame rewrites, random frames under four idle mixes");
		if (error_count == 0) begin
			$display("tb_yuyv_to_rgb_downscaler_core: clean");
		end else begin
			$display("tb_yuyv_to_rgb_downscaler_core: errors");
		end
		$finish;
	end

endmodule
